// ===== hw/rtl/ufbd_pkg.sv =====
package ufbd_pkg;

  // Field widths fixed by the register and the item format.
  localparam int unsigned RefClkW  = 30;
  localparam int unsigned BaudW    = 24;
  localparam int unsigned WordW    = 16;
  localparam int unsigned MsCountW = 24;
  localparam int unsigned ErrW     = 32;
  localparam int unsigned CodeW    = 3;

  // Shared divider: 32-bit divisor, 32- or 48-bit dividend.
  localparam int unsigned DivisorW  = 32;
  localparam int unsigned DividendW = 48;
  localparam int unsigned DivCntW   = 6;

  localparam logic [RefClkW-1:0] RefClkReset = 30'd80000000;
  localparam logic [DivisorW-1:0] PercentDiv = 32'd100;
  localparam logic [DivisorW-1:0] MsPerSec   = 32'd1000;

  localparam logic [CodeW-1:0] CodeDiv1 = 3'h5;
  localparam logic [CodeW-1:0] CodeDiv2 = 3'h4;
  localparam logic [CodeW-1:0] CodeDiv3 = 3'h3;
  localparam logic [CodeW-1:0] CodeDiv4 = 3'h2;
  localparam logic [CodeW-1:0] CodeDiv5 = 3'h1;
  localparam logic [CodeW-1:0] CodeDiv6 = 3'h0;
  localparam logic [CodeW-1:0] CodeDiv7 = 3'h6;

  // Map a pre-divider value to its register code.
  function automatic logic [CodeW-1:0] div_code(input logic [CodeW-1:0] pre);
    logic [CodeW-1:0] code;
    unique case (pre)
      3'd1:    code = CodeDiv1;
      3'd2:    code = CodeDiv2;
      3'd3:    code = CodeDiv3;
      3'd4:    code = CodeDiv4;
      3'd5:    code = CodeDiv5;
      3'd6:    code = CodeDiv6;
      3'd7:    code = CodeDiv7;
      default: code = CodeDiv1;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/uart_fractional_baud_divisor_core.sv =====
// Fractional baud divisor calculator. Pulse start with baud_rate while busy
// is low; busy stays high until the result appears on the result ports for
// exactly one cycle, marked by done. The receiver cannot stall the block, so
// capture the result in the done cycle. A binary GCD runs first, one shift
// or subtract-and-shift per cycle. Seven to eleven divisions follow on one
// shared restoring divider that retires one quotient bit per cycle; the
// achieved-rate division has a 48-bit dividend. A request that misses
// tolerance skips the last two divisions. A zero rate or clock goes from idle
// straight to the fail state, which raises done. Write ref_clock_hz through
// cfg_we/cfg_wdata only while busy is low. ok low means the achieved rate
// misses the request by 3 percent or more, or the request or clock is zero;
// all other fields are then zero.
module uart_fractional_baud_divisor_core
  import ufbd_pkg::*;
#(
  parameter int unsigned FRACTION_MAX = 65535
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RefClkW-1:0]  cfg_wdata,
  input  logic                start,
  input  logic [BaudW-1:0]    baud_rate,
  output logic                busy,
  output logic                done,
  output logic                ok,
  output logic [CodeW-1:0]    ref_div_code,
  output logic [WordW-1:0]    incr_value,
  output logic [WordW-1:0]    mod_value,
  output logic [MsCountW-1:0] one_ms_count,
  output logic [ErrW-1:0]     baud_error
);

  localparam logic [DivisorW-1:0] FracMax  = DivisorW'(FRACTION_MAX);
  localparam logic [DivisorW-1:0] FracMax7 = DivisorW'(7 * FRACTION_MAX);

  // Sequencer codes.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_GCD  = 5'd1;
  localparam logic [4:0] S_NUM  = 5'd2;   // num = clk / g
  localparam logic [4:0] S_DEN  = 5'd3;   // den = 16*baud / g
  localparam logic [4:0] S_CHK  = 5'd4;   // decide on scaling
  localparam logic [4:0] S_M    = 5'd5;   // ceil(num / 7*fmax)
  localparam logic [4:0] S_N    = 5'd6;   // ceil(den / fmax)
  localparam logic [4:0] S_SNUM = 5'd7;   // num / s
  localparam logic [4:0] S_SDEN = 5'd8;   // den / s
  localparam logic [4:0] S_PRE  = 5'd9;   // ceil(num / fmax)
  localparam logic [4:0] S_ACH  = 5'd10;  // clk*den / (16*num)
  localparam logic [4:0] S_TOL  = 5'd11;  // baud / 100
  localparam logic [4:0] S_EVAL = 5'd12;
  localparam logic [4:0] S_MOD  = 5'd13;  // num / pre
  localparam logic [4:0] S_MS   = 5'd14;  // clk / (1000*pre)
  localparam logic [4:0] S_OUT  = 5'd15;
  localparam logic [4:0] S_FAIL = 5'd16;

  logic [4:0]           state;
  logic [RefClkW-1:0]   ref_clock_hz;
  logic [BaudW-1:0]     baud;

  // GCD working registers.
  logic [RefClkW-1:0]   ga, gb;
  logic [4:0]           gk;
  logic [RefClkW-1:0]   g;

  // Fraction terms and intermediate results.
  logic [DivisorW-1:0]  num, den, scale;
  logic [CodeW-1:0]     pre;
  logic [DividendW-1:0] achieved;
  logic [19:0]          tol;
  logic [ErrW-1:0]      err_sat;

  // Shared bit-serial restoring divider.
  logic                 issued;
  logic                 dbusy;
  logic [DividendW-1:0] dq;
  logic [DivisorW-1:0]  drem;
  logic [DivisorW-1:0]  dd;
  logic [DivCntW-1:0]   dcnt;
  logic [DivisorW:0]    rem_sh;
  logic                 q_bit;

  logic [DivisorW-1:0]  op_dvd;
  logic [DivisorW-1:0]  op_dvs;
  logic                 op_wide;
  logic [DividendW-1:0] prod;
  logic [DividendW-1:0] quot;
  logic [DivisorW-1:0]  q32;
  logic                 div_fin;

  logic [DividendW-1:0] err_full;
  logic [DividendW-1:0] baud_ext;

  assign busy = (state != S_IDLE);

  // Advance one quotient bit: shift the next dividend bit into the remainder
  // and subtract where it fits.
  assign rem_sh = {drem, dq[DividendW-1]};
  assign q_bit  = (rem_sh >= {1'b0, dd});

  assign quot    = dq;
  assign q32     = dq[DivisorW-1:0];
  assign div_fin = issued && !dbusy;

  // Widen the clock and the reduced denominator; den fits 16 bits here.
  assign prod = DividendW'(ref_clock_hz) * DividendW'(den[WordW-1:0]);

  assign baud_ext = DividendW'(baud);
  assign err_full = (achieved >= baud_ext) ? (achieved - baud_ext) : (baud_ext - achieved);

  // Operand selection for the divider, by step.
  always_comb begin
    op_dvd  = '0;
    op_dvs  = 32'd1;
    op_wide = 1'b0;
    unique case (state)
      S_NUM: begin
        op_dvd = DivisorW'(ref_clock_hz);
        op_dvs = DivisorW'(g);
      end
      S_DEN: begin
        op_dvd = DivisorW'({baud, 4'b0000});
        op_dvs = DivisorW'(g);
      end
      S_M: begin
        op_dvd = num - 32'd1;
        op_dvs = FracMax7;
      end
      S_N: begin
        op_dvd = den - 32'd1;
        op_dvs = FracMax;
      end
      S_SNUM: begin
        op_dvd = num;
        op_dvs = scale;
      end
      S_SDEN: begin
        op_dvd = den;
        op_dvs = scale;
      end
      S_PRE: begin
        op_dvd = num - 32'd1;
        op_dvs = FracMax;
      end
      S_ACH: begin
        op_dvs  = {num[DivisorW-5:0], 4'b0000};
        op_wide = 1'b1;
      end
      S_TOL: begin
        op_dvd = DivisorW'(baud);
        op_dvs = PercentDiv;
      end
      S_MOD: begin
        op_dvd = num;
        op_dvs = DivisorW'(pre);
      end
      S_MS: begin
        op_dvd = DivisorW'(ref_clock_hz);
        op_dvs = DivisorW'(pre) * MsPerSec;
      end
      default: begin
        op_dvd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ref_clock_hz <= RefClkReset;
      issued       <= 1'b0;
      dbusy        <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        ref_clock_hz <= cfg_wdata;
      end

      // Divider: load on issue, then one bit per cycle.
      if (dbusy) begin
        dq   <= {dq[DividendW-2:0], q_bit};
        drem <= q_bit ? DivisorW'(rem_sh - {1'b0, dd}) : rem_sh[DivisorW-1:0];
        dcnt <= dcnt - 6'd1;
        if (dcnt == 6'd1) begin
          dbusy <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            baud <= baud_rate;
            ga   <= ref_clock_hz;
            gb   <= RefClkW'({baud_rate, 4'b0000});
            gk   <= '0;
            if (baud_rate == '0 || ref_clock_hz == '0) begin
              state <= S_FAIL;
            end else begin
              state <= S_GCD;
            end
          end
        end

        // Binary GCD: strip common twos, then subtract odd terms.
        S_GCD: begin
          priority if (ga == gb) begin
            g     <= ga << gk;
            state <= S_NUM;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + 5'd1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga > gb) begin
            ga <= (ga - gb) >> 1;
          end else begin
            gb <= (gb - ga) >> 1;
          end
        end

        S_CHK: begin
          if (num > FracMax7 || den > FracMax) begin
            state <= S_M;
          end else begin
            state <= S_PRE;
          end
        end

        // Reject when the achieved rate misses by the tolerance or more.
        S_EVAL: begin
          if (err_full >= DividendW'(tol)) begin
            state <= S_FAIL;
          end else begin
            err_sat <= (|err_full[DividendW-1:ErrW]) ? '1 : err_full[ErrW-1:0];
            state   <= S_MOD;
          end
        end

        S_OUT: begin
          done         <= 1'b1;
          ok           <= 1'b1;
          ref_div_code <= div_code(pre);
          incr_value   <= den[WordW-1:0] - 16'd1;
          baud_error   <= err_sat;
          state        <= S_IDLE;
        end

        S_FAIL: begin
          done         <= 1'b1;
          ok           <= 1'b0;
          ref_div_code <= '0;
          incr_value   <= '0;
          mod_value    <= '0;
          one_ms_count <= '0;
          baud_error   <= '0;
          state        <= S_IDLE;
        end

        // All remaining steps are divider steps: issue, wait, capture.
        default: begin
          if (!issued) begin
            issued <= 1'b1;
            dbusy  <= 1'b1;
            dd     <= op_dvs;
            drem   <= '0;
            dq     <= op_wide ? prod : {op_dvd, 16'b0};
            dcnt   <= op_wide ? 6'd48 : 6'd32;
          end else if (div_fin) begin
            issued <= 1'b0;
            unique case (state)
              S_NUM: begin
                num   <= q32;
                state <= S_DEN;
              end
              S_DEN: begin
                den   <= q32;
                state <= S_CHK;
              end
              S_M: begin
                scale <= q32 + 32'd1;
                state <= S_N;
              end
              S_N: begin
                if ((q32 + 32'd1) > scale) begin
                  scale <= q32 + 32'd1;
                end
                state <= S_SNUM;
              end
              S_SNUM: begin
                num   <= (q32 == '0) ? 32'd1 : q32;
                state <= S_SDEN;
              end
              S_SDEN: begin
                den   <= (q32 == '0) ? 32'd1 : q32;
                state <= S_PRE;
              end
              S_PRE: begin
                pre   <= CodeW'(q32 + 32'd1);
                state <= S_ACH;
              end
              S_ACH: begin
                achieved <= quot;
                state    <= S_TOL;
              end
              S_TOL: begin
                tol   <= {q32[18:0], 1'b0} + q32[19:0];
                state <= S_EVAL;
              end
              S_MOD: begin
                mod_value <= q32[WordW-1:0] - 16'd1;
                state     <= S_MS;
              end
              S_MS: begin
                one_ms_count <= q32[MsCountW-1:0];
                state        <= S_OUT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import ufbd_pkg::*;

  localparam int unsigned FracMax = 65535;

  // One computed divisor set, as it appears on the result ports.
  typedef struct packed {
    logic                ok;
    logic [CodeW-1:0]    code;
    logic [WordW-1:0]    incr;
    logic [WordW-1:0]    modv;
    logic [MsCountW-1:0] ms;
    logic [ErrW-1:0]     err;
  } divisor_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [RefClkW-1:0]  cfg_wdata = '0;
  logic                start = 1'b0;
  logic [BaudW-1:0]    baud_rate = '0;
  logic                busy;
  logic                done;
  logic                ok;
  logic [CodeW-1:0]    ref_div_code;
  logic [WordW-1:0]    incr_value;
  logic [WordW-1:0]    mod_value;
  logic [MsCountW-1:0] one_ms_count;
  logic [ErrW-1:0]     baud_error;

  divisor_t            pending_divisors[$];
  logic [RefClkW-1:0]  ref_hz = RefClkReset;
  int                  fail_count = 0;
  int                  sent_count = 0;
  int                  locked_count = 0;
  int                  setting_count = 0;
  bit                  idle_on = 1'b1;

  uart_fractional_baud_divisor_core #(.FRACTION_MAX(FracMax)) u_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .start, .baud_rate, .busy, .done, .ok,
    .ref_div_code, .incr_value, .mod_value, .one_ms_count, .baud_error
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] gcd_of(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Compute the divisor set the block must produce for one requested rate.
  function automatic divisor_t calc_divisor(input logic [BaudW-1:0] baud,
                                            input logic [RefClkW-1:0] ref_clk);
    divisor_t    r;
    logic [31:0] hz, num, den, g, pre, tol, m, n, s;
    logic [63:0] achieved, miss;
    r = '0;
    hz = 32'(ref_clk);
    if (baud == 0 || hz == 0) return r;
    den = 32'(baud) << 4;
    g = gcd_of(hz, den);
    num = hz / g;
    den = den / g;
    // Scale an oversized fraction down, never letting a term reach zero.
    if (num > FracMax * 7 || den > FracMax) begin
      m = (num - 1) / (FracMax * 7) + 1;
      n = (den - 1) / FracMax + 1;
      s = (m > n) ? m : n;
      num = num / s;
      den = den / s;
      if (num == 0) num = 1;
      if (den == 0) den = 1;
    end
    pre = (num - 1) / FracMax + 1;
    achieved = (64'(hz) * 64'(den)) / (64'(num) << 4);
    miss = (achieved >= 64'(baud)) ? achieved - 64'(baud) : 64'(baud) - achieved;
    tol = (32'(baud) / 100) * 3;
    if (miss >= 64'(tol)) return r;
    r.ok = 1'b1;
    case (pre)
      1: r.code = CodeDiv1;
      2: r.code = CodeDiv2;
      3: r.code = CodeDiv3;
      4: r.code = CodeDiv4;
      5: r.code = CodeDiv5;
      6: r.code = CodeDiv6;
      7: r.code = CodeDiv7;
      default: r.code = CodeDiv1;
    endcase
    r.incr = WordW'(den - 1);
    r.modv = WordW'(num / pre - 1);
    r.ms   = MsCountW'(hz / (1000 * pre));
    r.err  = (miss > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : miss[31:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare every done transfer against the oldest pending divisor set.
  always @(posedge clk) begin
    divisor_t want;
    if (!rst && done) begin
      if (pending_divisors.size() == 0) begin
        $error("result with no pending request");
        fail_count++;
      end else begin
        want = pending_divisors.pop_front();
        if (want.ok) locked_count++;
        check_field("ok", want.ok, ok);
        check_field("ref_div_code", want.code, ref_div_code);
        check_field("incr_value", want.incr, incr_value);
        check_field("mod_value", want.modv, mod_value);
        check_field("one_ms_count", want.ms, one_ms_count);
        check_field("baud_error", want.err, baud_error);
      end
    end
  end

  // Hold start until the block takes the request, then drop it and maybe idle.
  task automatic send_baud(input logic [BaudW-1:0] b);
    start <= 1'b1;
    baud_rate <= b;
    do @(posedge clk); while (busy);
    pending_divisors.push_back(calc_divisor(b, ref_hz));
    sent_count++;
    start <= 1'b0;
    @(posedge clk);
    if (idle_on && $urandom_range(99) < 24)
      repeat ($urandom_range(1, 600)) @(posedge clk);
  endtask

  // Write the reference clock only once every pending result has come back.
  task automatic set_ref_clock(input logic [RefClkW-1:0] hz);
    while (pending_divisors.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_we <= 1'b0;
    ref_hz = hz;
    setting_count++;
    @(posedge clk);
  endtask

  function automatic logic [BaudW-1:0] pick_baud();
    logic [31:0] top;
    int          sel;
    sel = $urandom_range(99);
    top = 32'(ref_hz) / 16;
    if (top > 16000000) top = 16000000;
    if (top < 100) top = 100;
    if (sel < 25) begin
      case ($urandom_range(7))
        0: return 300;
        1: return 1200;
        2: return 9600;
        3: return 19200;
        4: return 57600;
        5: return 115200;
        6: return 921600;
        default: return 3000000;
      endcase
    end
    if (sel < 75) return BaudW'($urandom_range(100, top));
    if (sel < 85) return BaudW'($urandom_range(100, 2000));
    return BaudW'($urandom);
  endfunction

  // Edges of the rate field and the zero and sub-hundred special cases.
  task automatic test_directed_baud();
    send_baud('0);
    send_baud(1);
    send_baud(99);
    send_baud(100);
    send_baud(9600);
    send_baud(115200);
    send_baud(16000000);
    send_baud('1);
    send_baud(24'h555555);
    send_baud(24'hAAAAAA);
  endtask

  // Reference clock extremes, zero clock, and fractions that need scaling.
  task automatic test_directed_ref();
    set_ref_clock(0);
    send_baud(9600);
    set_ref_clock(1);
    send_baud(1);
    send_baud(100);
    set_ref_clock(1000000000);
    send_baud(9600);
    send_baud(16000000);
    set_ref_clock('1);
    send_baud(115200);
    send_baud(110);
    set_ref_clock(999999937);
    send_baud(9600);
    send_baud(300);
    set_ref_clock(RefClkReset);
    send_baud(115200);
  endtask

  task automatic test_random_rates(input int count, input logic [RefClkW-1:0] hz);
    set_ref_clock(hz);
    repeat (count) send_baud(pick_baud());
  endtask

  // Back-to-back requests with the random idle gaps turned off.
  task automatic test_no_idle(input int count);
    idle_on = 1'b0;
    repeat (count) send_baud(pick_baud());
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_baud();
    test_directed_ref();
    test_random_rates(350, RefClkReset);
    test_no_idle(150);
    test_random_rates(300, 1000000000);
    test_random_rates(300, RefClkW'($urandom_range(1000000, 1000000000)));
    test_random_rates(250, 48000000);
    test_random_rates(250, RefClkW'($urandom));
    test_random_rates(225, '1);
    while (pending_divisors.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Sent %0d rate requests across %0d clock settings; %0d locked within tolerance.",
             sent_count, setting_count, locked_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #40000000;
    $display("Timed out with %0d results pending", pending_divisors.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
